FILE: hw/rtl/lwg_pkg.sv
`timescale 1ns / 1ps

package lwg_pkg;

	localparam int TableDepth = 256;
	localparam int PhaseWidth = $clog2(TableDepth);

	// Waveform codes on wave_select
	typedef enum logic [1:0] {
		WAVE_SINE     = 2'b00,
		WAVE_TRIANGLE = 2'b01,
		WAVE_SQUARE   = 2'b10,
		WAVE_SAWTOOTH = 2'b11
	} wave_sel_t;

	// One full sine period, midpoint 128, full scale 0..255
	localparam logic [7:0] SINE_TABLE [0:TableDepth-1] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
		8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
		8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
		8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
		8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
		8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
		8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
		8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
		8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
		8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
		8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
		8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
		8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
		8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
		8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
		8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
		8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
		8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
		8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
		8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
		8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
		8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
		8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
		8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
		8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
		8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
		8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
		8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
		8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
	};

endpackage

FILE: hw/rtl/lut_waveform_generator_core.sv
`timescale 1ns / 1ps

// Table-driven waveform generator with PWM output. Each input beat is one
// tick: the rate counter steps, reloading from rate and advancing the phase
// whenever it passes 255, so the phase moves once every 256 - rate ticks.
// The sample (sine table, triangle, square or sawtooth per wave_select) and
// the PWM bit against an 8-bit count that steps once per beat come out as
// one result beat per input beat. One beat per clock is sustained while
// out_stall is low; each beat passes the stage 1 register (phase and PWM
// count) and then the output register after the table lookup and compare.
module lut_waveform_generator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rate,
	input  logic [1:0] wave_select,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] level,
	output logic       pwm_out
);

	logic [7:0]                     rate_count_q;
	logic [lwg_pkg::PhaseWidth-1:0] phase_q;
	logic [7:0]                     pwm_count_q;

	logic                           valid_s1;
	logic [lwg_pkg::PhaseWidth-1:0] phase_s1;
	logic [7:0]                     pwm_count_s1;
	lwg_pkg::wave_sel_t             wave_sel_s1;

	logic                           advance;
	logic                           in_accept;
	logic                           wrap;
	logic [lwg_pkg::PhaseWidth-1:0] phase_next;
	logic [7:0]                     level_c;
	logic                           pwm_c;

	// Handshake: stage 1 moves when the output register is free or draining
	assign advance   = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign wrap      = (rate_count_q == 8'hFF);

	// Phase after this tick
	assign phase_next = wrap ? phase_q + lwg_pkg::PhaseWidth'(1) : phase_q;

	// Tick state, updated once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_count_q <= '0;
			phase_q      <= '0;
			pwm_count_q  <= '0;
		end else if (in_accept) begin
			rate_count_q <= wrap ? rate : rate_count_q + 8'd1;
			phase_q      <= phase_next;
			pwm_count_q  <= pwm_count_q + 8'd1;
		end
	end

	// Stage 1: phase after this tick and PWM count before its increment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			phase_s1     <= phase_next;
			pwm_count_s1 <= pwm_count_q;
			wave_sel_s1  <= lwg_pkg::wave_sel_t'(wave_select);
		end
	end

	lwg_wave_shaper u_shaper (
		.phase     (phase_s1),
		.wave_sel  (wave_sel_s1),
		.pwm_count (pwm_count_s1),
		.level     (level_c),
		.pwm_bit   (pwm_c)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			level   <= level_c;
			pwm_out <= pwm_c;
		end
	end

	// A full pipeline under output backpressure must hold off the input
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && valid_s1) |-> in_stall)
		else $error("input not stalled with full pipeline");

	// An accepted beat always lands in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted beat lost before stage 1");

	// Phase moves only on an accepted beat at rate counter wrap
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(phase_q) |-> $past(in_accept && wrap))
		else $error("phase changed without rate counter wrap");

	// PWM count steps by one per accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (pwm_count_q == $past(pwm_count_q) + 8'd1))
		else $error("pwm count did not step");

endmodule

FILE: hw/rtl/lwg_wave_shaper.sv
`timescale 1ns / 1ps

// Maps phase to the selected waveform sample and forms the PWM bit.
module lwg_wave_shaper (
	input  logic [lwg_pkg::PhaseWidth-1:0] phase,
	input  lwg_pkg::wave_sel_t             wave_sel,
	input  logic [7:0]                     pwm_count,
	output logic [7:0]                     level,
	output logic                           pwm_bit
);

	// Waveform select; the triangle's falling half is 2*(255-p) mod 256
	always_comb begin
		case (wave_sel)
			lwg_pkg::WAVE_SINE: begin
				level = lwg_pkg::SINE_TABLE[phase];
			end
			lwg_pkg::WAVE_TRIANGLE: begin
				level = phase[7] ? {~phase[6:0], 1'b0} : {phase[6:0], 1'b0};
			end
			lwg_pkg::WAVE_SQUARE: begin
				level = phase[7] ? 8'd0 : 8'd255;
			end
			lwg_pkg::WAVE_SAWTOOTH: begin
				level = phase;
			end
			default: begin
				level = phase;
			end
		endcase
	end

	// PWM high while the count is at or below the level
	assign pwm_bit = (pwm_count <= level);

endmodule

FILE: tb/tb_lut_waveform_generator_core.sv
`timescale 1ns / 1ps

module tb_lut_waveform_generator_core;

	localparam int ClkPeriod  = 12;
	localparam int ResetTicks = 6;
	localparam int IdleLimit  = 4000;
	localparam int DrainTicks = 12;
	localparam int ShowLimit  = 10;

	typedef struct packed {
		logic [7:0] level;
		logic       pwm;
	} sample_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rate = 8'd0;
	logic [1:0] wave_select = lwg_pkg::WAVE_SINE;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] level;
	logic       pwm_out;

	// Predictor state: mirrors the generator's counters
	logic [7:0] gen_rate_count = 8'd0;
	logic [7:0] gen_phase = 8'd0;
	logic [7:0] gen_pwm_count = 8'd0;

	sample_t     sample_q[$];
	int          fail_count = 0;
	int          idle_ticks = 0;
	int          burst_left = 0;
	int unsigned stall_span = 0;
	stall_mode_t stall_mode = STALL_NONE;

	lut_waveform_generator_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rate        (rate),
		.wave_select (wave_select),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.level       (level),
		.pwm_out     (pwm_out)
	);

	initial begin
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// Advance the generator by one tick and return the sample it should emit
	function automatic sample_t tick_sample(input logic [7:0] r,
		input lwg_pkg::wave_sel_t w);
		sample_t s;
		if (gen_rate_count == 8'd255) begin
			gen_rate_count = r;
			gen_phase      = gen_phase + 8'd1;
		end else begin
			gen_rate_count = gen_rate_count + 8'd1;
		end
		case (w)
			lwg_pkg::WAVE_SINE:     s.level = lwg_pkg::SINE_TABLE[gen_phase];
			lwg_pkg::WAVE_TRIANGLE: s.level = gen_phase[7] ?
				8'(2 * (8'd255 - gen_phase)) : 8'(2 * gen_phase);
			lwg_pkg::WAVE_SQUARE:   s.level = gen_phase[7] ? 8'd0 : 8'd255;
			default:                s.level = gen_phase;
		endcase
		s.pwm         = (gen_pwm_count <= s.level);
		gen_pwm_count = gen_pwm_count + 8'd1;
		return s;
	endfunction

	// Input beats feed the predictor; output beats are checked against it
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && in_valid && !in_stall) begin
			sample_q.push_back(tick_sample(rate, lwg_pkg::wave_sel_t'(wave_select)));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (sample_q.size() == 0) begin
				fail_count++;
				if (fail_count <= ShowLimit)
					$display("unexpected beat: level=%0d pwm=%0b", level, pwm_out);
			end else begin
				want = sample_q.pop_front();
				if (level !== want.level || pwm_out !== want.pwm) begin
					fail_count++;
					if (fail_count <= ShowLimit)
						$display("bad beat: level exp %0d got %0d, pwm exp %0b got %0b",
							want.level, level, want.pwm, pwm_out);
				end
			end
		end
	end

	// Receiver stalls: modes of random length, including stretches with none
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(3));
			stall_span = $urandom_range(80, 8);
		end
		stall_span--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(9) < 6);
			default:     out_stall <= (stall_span[1:0] == 2'b11);
		endcase
	end

	// Watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_ticks = 0;
		else
			idle_ticks++;
		if (idle_ticks >= IdleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Send one tick; the sender may idle between bursts of random length
	task automatic send_tick(input logic [7:0] r, input lwg_pkg::wave_sel_t w);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			burst_left = $urandom_range(24, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		rate        <= r;
		wave_select <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// Phase still 0 after reset: every shape at its start, rate extremes
	task automatic test_shapes_at_start();
		logic [7:0] rates [4] = '{8'd0, 8'd255, 8'h55, 8'hAA};
		for (int i = 0; i < 24; i++)
			send_tick(rates[i % 4], lwg_pkg::wave_sel_t'((i / 4 + i) % 4));
	endtask

	// Rate 0: phase moves once every 256 ticks
	task automatic test_slow_rate();
		for (int i = 0; i < 500; i++)
			send_tick(8'd0, lwg_pkg::wave_sel_t'($urandom_range(3)));
	endtask

	// Rate 255: once the rate counter reaches 255, the phase moves each tick
	task automatic test_fast_rate();
		for (int i = 0; i < 300; i++)
			send_tick(8'd255, lwg_pkg::wave_sel_t'($urandom_range(3)));
	endtask

	// Mixed rates, weighted toward fast ones so the phase keeps moving
	task automatic test_random_mix();
		logic [7:0] r;
		for (int i = 0; i < 430; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: r = 8'd255;
				5, 6, 7:       r = 8'($urandom_range(254, 224));
				8:             r = 8'($urandom_range(31, 0));
				default:       r = 8'($urandom_range(255, 0));
			endcase
			send_tick(r, lwg_pkg::wave_sel_t'($urandom_range(3)));
		end
	endtask

	initial begin
		repeat (ResetTicks) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_shapes_at_start();
		test_slow_rate();
		test_fast_rate();
		test_random_mix();
		in_valid <= 1'b0;

		while (sample_q.size() != 0) @(posedge clk);
		repeat (DrainTicks) @(posedge clk);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
